[src/htb_pkg.sv]
`default_nettype none

package htb_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 13;
    localparam int LIMIT_W   = 17;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 13'd4096;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [3:0] LETTER_OFFSET   = 4'd9;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_BADCHAR  = 2'd1,
        CAUSE_CAPACITY = 2'd2,
        CAUSE_ODD      = 2'd3
    } fail_cause_t;

    typedef enum logic [1:0] {
        CLS_TERM  = 2'd0,
        CLS_SEP   = 2'd1,
        CLS_DIGIT = 2'd2,
        CLS_BAD   = 2'd3
    } char_class_kind_t;

    typedef struct packed {
        char_class_kind_t kind;
        logic [3:0]       nibble;
    } char_class_t;

endpackage

`default_nettype wire

[src/htb_if.sv]
`default_nettype none

interface htb_text_if;
    logic                          valid;
    logic                          ready;
    logic [htb_pkg::CHAR_W-1:0]    text_char;

    modport source (output valid, output text_char, input ready);
    modport sink (input valid, input text_char, output ready);
endinterface

interface htb_result_if;
    logic                          valid;
    logic                          ready;
    htb_pkg::result_kind_t         result_kind;
    logic [htb_pkg::CHAR_W-1:0]    data_byte;
    logic [htb_pkg::COUNT_W-1:0]   byte_count;
    htb_pkg::fail_cause_t          fail_cause;

    modport source (output valid, output result_kind, output data_byte,
                    output byte_count, output fail_cause, input ready);
    modport sink (input valid, input result_kind, input data_byte,
                  input byte_count, input fail_cause, output ready);
endinterface

interface htb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [htb_pkg::COUNT_W-1:0]   byte_capacity;

    modport source (output valid, output byte_capacity, input ready);
    modport sink (input valid, input byte_capacity, output ready);
endinterface

`default_nettype wire

[src/hex_text_to_bytes.sv]
`default_nettype none

// Streaming hex text decoder. One character is taken per beat on text, a zero character
// ends the string. Space, tab, CR, LF and colon are skipped, hex digits pair up high nibble
// first, and each byte leaves as a data result with its running count; the terminator gives
// success with the total or failure for an odd digit count, and a bad character or a byte over
// capacity fails at once with its cause. After a failure the rest of the string up to and including
// its terminator gives no result, and the consumer drops the bytes already seen. A character goes
// from the input register through the classify and decode logic into the result register, so the
// block takes one character every clock cycle; only a stalled result register holds the input side.
// The user must write capacity on cfg only while idle; the block itself does not enforce it.
module hex_text_to_bytes (
    input  wire logic     clk,
    input  wire logic     rst_n,
    htb_cfg_if.sink       cfg,
    htb_text_if.sink      text,
    htb_result_if.source  result
);

    localparam logic [htb_pkg::LIMIT_W-1:0] MaxBytesW = htb_pkg::LIMIT_W'(htb_pkg::MAX_BYTES);

    logic [htb_pkg::COUNT_W-1:0] capacity_reg;
    logic [htb_pkg::COUNT_W-1:0] byte_limit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= htb_pkg::CAPACITY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            capacity_reg <= cfg.byte_capacity;
        end
    end

    // effective limit is the smaller of register and build maximum
    assign byte_limit = ({{(htb_pkg::LIMIT_W - htb_pkg::COUNT_W){1'b0}}, capacity_reg} > MaxBytesW)
                        ? MaxBytesW[htb_pkg::COUNT_W-1:0] : capacity_reg;

    htb_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_limit (byte_limit),
        .text       (text),
        .result     (result)
    );

endmodule

`default_nettype wire

[src/htb_classify.sv]
`default_nettype none

module htb_classify (
    input  wire logic [htb_pkg::CHAR_W-1:0] text_char,
    output htb_pkg::char_class_t            char_class
);

    logic is_sep;
    logic is_num;
    logic is_lower;
    logic is_upper;

    always_comb
    begin
        is_sep   = (text_char == htb_pkg::CH_SPACE) || (text_char == htb_pkg::CH_TAB) ||
                   (text_char == htb_pkg::CH_CR) || (text_char == htb_pkg::CH_LF) ||
                   (text_char == htb_pkg::CH_COLON);
        is_num   = (text_char >= htb_pkg::CH_ZERO) && (text_char <= htb_pkg::CH_NINE);
        is_lower = (text_char >= htb_pkg::CH_LA) && (text_char <= htb_pkg::CH_LF_HEX);
        is_upper = (text_char >= htb_pkg::CH_UA) && (text_char <= htb_pkg::CH_UF);

        char_class.nibble = is_num ? text_char[3:0]
                                   : 4'(text_char[3:0] + htb_pkg::LETTER_OFFSET);
        if (text_char == htb_pkg::CH_NUL)
        begin
            char_class.kind = htb_pkg::CLS_TERM;
        end
        else if (is_sep)
        begin
            char_class.kind = htb_pkg::CLS_SEP;
        end
        else if (is_num || is_lower || is_upper)
        begin
            char_class.kind = htb_pkg::CLS_DIGIT;
        end
        else
        begin
            char_class.kind = htb_pkg::CLS_BAD;
        end
    end

endmodule

`default_nettype wire

[src/htb_decoder.sv]
`default_nettype none

module htb_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [htb_pkg::COUNT_W-1:0]  byte_limit,
    htb_text_if.sink                          text,
    htb_result_if.source                      result
);

    logic                          char_valid_reg;
    logic [htb_pkg::CHAR_W-1:0]    char_reg;
    htb_pkg::char_class_t          char_class;

    logic [3:0]                    high_nibble_reg;
    logic [3:0]                    high_nibble_next;
    logic                          nibble_pending_reg;
    logic                          nibble_pending_next;
    logic [htb_pkg::COUNT_W-1:0]   bytes_done_reg;
    logic [htb_pkg::COUNT_W-1:0]   bytes_done_next;
    logic                          failed_skip_reg;
    logic                          failed_skip_next;

    logic                          res_valid_reg;
    htb_pkg::result_kind_t         res_kind_reg;
    logic [htb_pkg::CHAR_W-1:0]    res_byte_reg;
    logic [htb_pkg::COUNT_W-1:0]   res_count_reg;
    htb_pkg::fail_cause_t          res_cause_reg;

    logic                          res_fire;
    htb_pkg::result_kind_t         res_kind_next;
    logic [htb_pkg::CHAR_W-1:0]    res_byte_next;
    logic [htb_pkg::COUNT_W-1:0]   res_count_next;
    htb_pkg::fail_cause_t          res_cause_next;

    logic                          out_free;
    logic                          advance;

    htb_classify u_classify (
        .text_char  (char_reg),
        .char_class (char_class)
    );

    assign out_free   = !res_valid_reg || result.ready;
    assign advance    = char_valid_reg && out_free;
    assign text.ready = !char_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            char_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            char_reg <= text.text_char;
        end
    end

    // per-character decode
    always_comb
    begin
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        bytes_done_next     = bytes_done_reg;
        failed_skip_next    = failed_skip_reg;
        res_fire            = 1'b0;
        res_kind_next       = htb_pkg::KIND_DATA;
        res_byte_next       = '0;
        res_count_next      = bytes_done_reg;
        res_cause_next      = htb_pkg::CAUSE_NONE;

        case (char_class.kind)
            htb_pkg::CLS_TERM:
            begin
                high_nibble_next    = '0;
                nibble_pending_next = 1'b0;
                bytes_done_next     = '0;
                failed_skip_next    = 1'b0;
                res_fire            = !failed_skip_reg;
                if (nibble_pending_reg)
                begin
                    res_kind_next  = htb_pkg::KIND_FAIL;
                    res_cause_next = htb_pkg::CAUSE_ODD;
                end
                else
                begin
                    res_kind_next  = htb_pkg::KIND_OK;
                end
            end
            htb_pkg::CLS_SEP:
            begin
                res_fire = 1'b0;
            end
            htb_pkg::CLS_BAD:
            begin
                if (!failed_skip_reg)
                begin
                    failed_skip_next = 1'b1;
                    res_fire         = 1'b1;
                    res_kind_next    = htb_pkg::KIND_FAIL;
                    res_cause_next   = htb_pkg::CAUSE_BADCHAR;
                end
            end
            htb_pkg::CLS_DIGIT:
            begin
                if (!failed_skip_reg)
                begin
                    if (!nibble_pending_reg)
                    begin
                        high_nibble_next    = char_class.nibble;
                        nibble_pending_next = 1'b1;
                    end
                    else if (bytes_done_reg >= byte_limit)
                    begin
                        failed_skip_next = 1'b1;
                        res_fire         = 1'b1;
                        res_kind_next    = htb_pkg::KIND_FAIL;
                        res_cause_next   = htb_pkg::CAUSE_CAPACITY;
                    end
                    else
                    begin
                        bytes_done_next     = htb_pkg::COUNT_W'(bytes_done_reg + 1'b1);
                        nibble_pending_next = 1'b0;
                        high_nibble_next    = '0;
                        res_fire            = 1'b1;
                        res_byte_next       = {high_nibble_reg, char_class.nibble};
                        res_count_next      = bytes_done_next;
                    end
                end
            end
            default:
            begin
                res_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
            bytes_done_reg     <= '0;
            failed_skip_reg    <= 1'b0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                high_nibble_reg    <= high_nibble_next;
                nibble_pending_reg <= nibble_pending_next;
                bytes_done_reg     <= bytes_done_next;
                failed_skip_reg    <= failed_skip_next;
            end
            if (out_free)
            begin
                res_valid_reg <= advance && res_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            res_kind_reg  <= res_kind_next;
            res_byte_reg  <= res_byte_next;
            res_count_reg <= res_count_next;
            res_cause_reg <= res_cause_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.result_kind = res_kind_reg;
    assign result.data_byte   = res_byte_reg;
    assign result.byte_count  = res_count_reg;
    assign result.fail_cause  = res_cause_reg;

    // skip mode swallows every character, the terminator too, and the terminator ends it
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && failed_skip_reg && char_class.kind != htb_pkg::CLS_TERM)
        |=> !res_valid_reg)
        else $error("result produced while skipping");

    // terminator starts a fresh string
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && char_class.kind == htb_pkg::CLS_TERM)
        |=> (bytes_done_reg == '0 && !nibble_pending_reg && !failed_skip_reg))
        else $error("string state not cleared by terminator");

    a_nibble_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !nibble_pending_reg |-> (high_nibble_reg == 4'd0))
        else $error("stale high nibble");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && !out_free) |=> ($stable(bytes_done_reg) && $stable(char_reg)))
        else $error("state moved while output stalled");

endmodule

`default_nettype wire
